### rtl/core/button_debounce_click_classifier_defines.svh
// ----------------------------------------------------------------------------
// Button debounce click classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce click classifier package
// Shared types, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package bdcc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [IDX_W-1:0] REG_DOUBLE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_SINGLE   = 2'd3;

  // Reset values of the threshold registers.
  localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd20;
  localparam logic [CFG_W-1:0] RST_LONG     = 16'd1000;
  localparam logic [CFG_W-1:0] RST_DOUBLE   = 16'd300;
  localparam logic [CFG_W-1:0] RST_SINGLE   = 16'd300;

  // Result codes.
  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_SINGLE = 2'd1,
    CODE_DOUBLE = 2'd2,
    CODE_LONG   = 2'd3
  } code_t;

  // Threshold set handed to the classifier.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] double_click_window;
    logic [CFG_W-1:0] single_click_timeout;
  } cfg_t;

  // One poll of the button.
  typedef struct packed {
    logic              raw_pressed;
    logic [TIME_W-1:0] now_time;
  } sample_t;

endpackage

### rtl/core/bdcc_cfg.sv
// ----------------------------------------------------------------------------
// Button debounce click classifier configuration registers
// Holds the four 16-bit thresholds written through the plain write port.
// ----------------------------------------------------------------------------
module bdcc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bdcc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bdcc_pkg::CFG_W-1:0] cfg_wdata,
  output bdcc_pkg::cfg_t             cfg
);

  bdcc_pkg::cfg_t cfg_r;
  bdcc_pkg::cfg_t cfg_nxt;

  // Decode the register index of a write.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bdcc_pkg::REG_DEBOUNCE: cfg_nxt.debounce_time        = cfg_wdata;
        bdcc_pkg::REG_LONG:     cfg_nxt.long_press_time      = cfg_wdata;
        bdcc_pkg::REG_DOUBLE:   cfg_nxt.double_click_window  = cfg_wdata;
        bdcc_pkg::REG_SINGLE:   cfg_nxt.single_click_timeout = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  // Threshold registers with their power-on values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time        <= bdcc_pkg::RST_DEBOUNCE;
      cfg_r.long_press_time      <= bdcc_pkg::RST_LONG;
      cfg_r.double_click_window  <= bdcc_pkg::RST_DOUBLE;
      cfg_r.single_click_timeout <= bdcc_pkg::RST_SINGLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/bdcc_core.sv
// ----------------------------------------------------------------------------
// Button debounce click classifier core
// Debounce and click state, updated once per poll when the poll advances.
// ----------------------------------------------------------------------------
module bdcc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  bdcc_pkg::sample_t   smp,
  input  bdcc_pkg::cfg_t      cfg,
  output bdcc_pkg::code_t     code
);

  localparam int unsigned TW = bdcc_pkg::TIME_W;
  localparam int unsigned PW = bdcc_pkg::TIME_W - bdcc_pkg::CFG_W;

  logic          stable_r,     stable_nxt;
  logic          last_raw_r,   last_raw_nxt;
  logic [TW-1:0] raw_chg_r,    raw_chg_nxt;
  logic [TW-1:0] press_st_r,   press_st_nxt;
  logic          long_rep_r,   long_rep_nxt;
  logic          await_r,      await_nxt;
  logic [TW-1:0] first_rel_r,  first_rel_nxt;

  logic [TW-1:0] now_t;
  logic          raw;
  logic          changed;
  logic          deb_ok;
  logic          edge_hit;
  logic [TW-1:0] raw_age;
  logic [TW-1:0] press_age;
  logic [TW-1:0] rel_age;
  logic          long_due;
  logic          dbl_ok;
  logic          single_due;
  logic          long_tmp;
  logic          await_tmp;

  assign now_t = smp.now_time;
  assign raw   = smp.raw_pressed;

  // Elapsed times against the stored marks, all modulo 2^32.
  assign raw_age   = now_t - raw_chg_r;
  assign press_age = now_t - press_st_r;
  assign rel_age   = now_t - first_rel_r;

  // Debounce: a fresh change has zero age, so it passes only a zero threshold.
  assign changed  = raw != last_raw_r;
  assign deb_ok   = changed ? (cfg.debounce_time == '0)
                            : (raw_age >= {{PW{1'b0}}, cfg.debounce_time});
  assign edge_hit = deb_ok && (stable_r != raw);

  // Threshold checks, with marks reloaded by this poll reading as zero age.
  assign long_due   = edge_hit ? (cfg.long_press_time == '0)
                               : (press_age >= {{PW{1'b0}}, cfg.long_press_time});
  assign dbl_ok     = rel_age <= {{PW{1'b0}}, cfg.double_click_window};
  assign single_due = edge_hit ? (cfg.single_click_timeout == '0)
                               : (rel_age >= {{PW{1'b0}}, cfg.single_click_timeout});

  // Click classification and next state.
  always_comb begin
    last_raw_nxt  = raw;
    raw_chg_nxt   = changed ? now_t : raw_chg_r;
    stable_nxt    = edge_hit ? raw : stable_r;
    press_st_nxt  = press_st_r;
    long_rep_nxt  = long_rep_r;
    await_nxt     = await_r;
    first_rel_nxt = first_rel_r;
    long_tmp      = long_rep_r;
    await_tmp     = await_r;
    code          = bdcc_pkg::CODE_NONE;
    if (stable_nxt) begin
      if (edge_hit) begin
        press_st_nxt = now_t;
        long_tmp     = 1'b0;
      end
      long_rep_nxt = long_tmp;
      if (!long_tmp && long_due) begin
        long_rep_nxt = 1'b1;
        await_nxt    = 1'b0;
        code         = bdcc_pkg::CODE_LONG;
      end
    end else if (edge_hit && long_rep_r) begin
      // Release that ends a long press is swallowed.
      long_rep_nxt = 1'b0;
    end else if (edge_hit && await_r && dbl_ok) begin
      await_nxt = 1'b0;
      code      = bdcc_pkg::CODE_DOUBLE;
    end else begin
      if (edge_hit) begin
        await_tmp     = 1'b1;
        first_rel_nxt = now_t;
      end
      await_nxt = await_tmp;
      if (await_tmp && single_due) begin
        await_nxt = 1'b0;
        code      = bdcc_pkg::CODE_SINGLE;
      end
    end
  end

  // State registers, updated when a poll moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= 1'b0;
      last_raw_r  <= 1'b0;
      raw_chg_r   <= '0;
      press_st_r  <= '0;
      long_rep_r  <= 1'b0;
      await_r     <= 1'b0;
      first_rel_r <= '0;
    end else if (adv) begin
      stable_r    <= stable_nxt;
      last_raw_r  <= last_raw_nxt;
      raw_chg_r   <= raw_chg_nxt;
      press_st_r  <= press_st_nxt;
      long_rep_r  <= long_rep_nxt;
      await_r     <= await_nxt;
      first_rel_r <= first_rel_nxt;
    end
  end

endmodule

### rtl/core/button_debounce_click_classifier.sv
// ----------------------------------------------------------------------------
// Button debounce click classifier
// Debounces polled button levels and gives one click code for every poll.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                               | Beat
//  --------+-------------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_raw_pressed, | one poll: level and tick count
//          | in_now_time                         |
//  out     | out_valid, out_stall, out_click_code| one click code per poll
//  cfg     | cfg_we, cfg_index, cfg_wdata        | one threshold register write
//
// A poll is registered in the input register, passes the classifier logic and
// lands in the result register; one beat per cycle sustained while out_stall is low.
// The classifier state advances as the poll moves into the result register.
// Reset is synchronous and restores the thresholds and the click state.
// A stalled result holds; the input register still takes one more beat behind it.
//
module button_debounce_click_classifier (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_raw_pressed,
  input  logic [31:0]                in_now_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_click_code,
  input  logic                       cfg_we,
  input  logic [bdcc_pkg::IDX_W-1:0] cfg_index,
  input  logic [bdcc_pkg::CFG_W-1:0] cfg_wdata
);

`include "button_debounce_click_classifier_defines.svh"

  logic              s1_valid_r, s1_valid_nxt;
  bdcc_pkg::sample_t s1_smp_r;
  logic              out_valid_r, out_valid_nxt;
  bdcc_pkg::code_t   out_code_r;
  bdcc_pkg::code_t   code;
  bdcc_pkg::cfg_t    cfg;
  logic              in_acc;
  logic              adv;

  bdcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .smp   (s1_smp_r),
    .cfg   (cfg),
    .code  (code)
  );

  // Handshake: the poll advances when the result register is free or draining.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_smp_r.raw_pressed <= in_raw_pressed;
      s1_smp_r.now_time    <= in_now_time;
    end
    if (adv) begin
      out_code_r <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_click_code = out_code_r;

  // The input side only backs up when a poll is waiting in the input register.
  `BDCC_ASSERT_SAME(a_stall_needs_item, in_stall, s1_valid_r, "in_stall without a held poll")
  // A poll that advances always shows up as a result next cycle.
  `BDCC_ASSERT_NEXT(a_adv_gives_result, adv, out_valid_r, "advanced poll lost")
  // A taken result with nothing behind it leaves the output empty.
  `BDCC_ASSERT_NEXT(a_no_invented_result, out_valid_r && !out_stall && !s1_valid_r,
    !out_valid_r, "result appeared without a poll")
  // An accepted beat is held in the input register next cycle.
  `BDCC_ASSERT_NEXT(a_accept_held, in_acc, s1_valid_r, "accepted poll dropped")

endmodule

### tb/sv/tb_button_debounce_click_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce click classifier testbench
// Sends button polls (raw level and tick count) through the block and checks
// every click code against an in-bench model of the debouncer and the
// single, double and long press classifier. Directed cases cover the codes,
// tick wrap-around, time stepping backwards and the threshold extremes.
// Random phases then send press and release gestures with bounce, random
// thresholds, random idling on both sides and a long result hold-off.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_classifier;

  typedef logic [bdcc_pkg::CFG_W-1:0] thr_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_raw_pressed = 1'b0;
  logic [31:0]                in_now_time = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_click_code;
  logic                       cfg_we = 1'b0;
  logic [bdcc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bdcc_pkg::CFG_W-1:0] cfg_wdata = '0;

  button_debounce_click_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_pressed (in_raw_pressed),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_click_code (out_click_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Thresholds as the block should hold them.
  thr_t thr_debounce;
  thr_t thr_long;
  thr_t thr_double;
  thr_t thr_single;

  // Debounce and click state of the model.
  logic        st_stable;
  logic        st_last_raw;
  logic [31:0] st_raw_change;
  logic [31:0] st_press_start;
  logic        st_long_done;
  logic        st_wait_second;
  logic [31:0] st_first_release;

  bdcc_pkg::code_t click_expect_q[$];
  int unsigned     error_count = 0;
  int unsigned     polls_sent = 0;
  int unsigned     codes_checked = 0;
  int unsigned     code_hits[4] = '{0, 0, 0, 0};
  bit              idle_on = 1'b1;
  int unsigned     stall_hold_req = 0;
  logic [31:0]     tick_now = '0;
  int unsigned     step_max = 4;

  initial begin
    forever #2 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Model of one poll: debounce, then classify the stable level.
  function automatic bdcc_pkg::code_t classify_poll(input logic raw, input logic [31:0] now);
    logic            settled;
    logic [31:0]     since;
    bdcc_pkg::code_t code;
    settled = 1'b0;
    code = bdcc_pkg::CODE_NONE;
    if (raw != st_last_raw) begin
      st_last_raw = raw;
      st_raw_change = now;
    end
    since = now - st_raw_change;
    if (since >= {16'd0, thr_debounce} && st_stable != st_last_raw) begin
      st_stable = st_last_raw;
      settled = 1'b1;
    end
    if (st_stable) begin
      if (settled) begin
        st_press_start = now;
        st_long_done = 1'b0;
      end
      since = now - st_press_start;
      if (!st_long_done && since >= {16'd0, thr_long}) begin
        st_long_done = 1'b1;
        st_wait_second = 1'b0;
        code = bdcc_pkg::CODE_LONG;
      end
    end else if (settled && st_long_done) begin
      // The release that ends a long press gives nothing.
      st_long_done = 1'b0;
    end else begin
      if (settled) begin
        since = now - st_first_release;
        if (st_wait_second && since <= {16'd0, thr_double}) begin
          st_wait_second = 1'b0;
          code = bdcc_pkg::CODE_DOUBLE;
        end else begin
          st_wait_second = 1'b1;
          st_first_release = now;
        end
      end
      since = now - st_first_release;
      if (code == bdcc_pkg::CODE_NONE && st_wait_second &&
          since >= {16'd0, thr_single}) begin
        st_wait_second = 1'b0;
        code = bdcc_pkg::CODE_SINGLE;
      end
    end
    return code;
  endfunction

  // Result checker: each accepted beat against the oldest expected code.
  always @(posedge clk) begin
    bdcc_pkg::code_t want;
    if (rst_n && out_valid && !out_stall) begin
      codes_checked++;
      code_hits[out_click_code]++;
      if (click_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected click code %0d with no poll pending", out_click_code);
      end else begin
        want = click_expect_q.pop_front();
        if (out_click_code !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: click code mismatch: expected %0d, got %0d",
                     want, out_click_code);
        end
      end
    end
  end

  // Result side: random stalls, or a long counted hold-off on request.
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (stall_hold_req > 0) begin
        n = stall_hold_req;
        stall_hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 34);
      end
    end
  end

  // Offer one poll, with random idle cycles first, and wait for the beat.
  task automatic send_poll(input logic raw, input logic [31:0] now);
    while (idle_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_pressed <= raw;
    in_now_time <= now;
    do @(posedge clk); while (in_stall);
    click_expect_q.push_back(classify_poll(raw, now));
    polls_sent++;
  endtask

  // Poll after dt more ticks.
  task automatic poll_after(input logic raw, input int unsigned dt);
    tick_now = tick_now + dt;
    send_poll(raw, tick_now);
  endtask

  // Stop offering and wait until every expected code has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (click_expect_q.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic set_threshold(input logic [bdcc_pkg::IDX_W-1:0] idx, input thr_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bdcc_pkg::REG_DEBOUNCE: thr_debounce = val;
      bdcc_pkg::REG_LONG:     thr_long = val;
      bdcc_pkg::REG_DOUBLE:   thr_double = val;
      bdcc_pkg::REG_SINGLE:   thr_single = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input thr_t deb, input thr_t lng, input thr_t dbl, input thr_t sgl);
    set_threshold(bdcc_pkg::REG_DEBOUNCE, deb);
    set_threshold(bdcc_pkg::REG_LONG, lng);
    set_threshold(bdcc_pkg::REG_DOUBLE, dbl);
    set_threshold(bdcc_pkg::REG_SINGLE, sgl);
  endtask

  // Hold one level for about span ticks, with contact bounce at the start.
  task automatic hold_level(input logic level, input int unsigned span);
    int unsigned elapsed;
    int unsigned dt;
    elapsed = 0;
    repeat ($urandom_range(2)) begin
      poll_after(!level, 1);
      poll_after(level, 1);
      elapsed += 2;
    end
    while (elapsed < span) begin
      dt = $urandom_range(1, step_max);
      poll_after(level, dt);
      elapsed += dt;
    end
  endtask

  // Default thresholds: every code, tick wrap-around and time going backwards.
  task automatic test_directed_defaults();
    send_poll(1'b0, 32'd0);
    // Single press and release, then a second one inside the window.
    send_poll(1'b1, 32'd5);
    send_poll(1'b1, 32'd30);
    send_poll(1'b0, 32'd60);
    send_poll(1'b0, 32'd80);
    send_poll(1'b1, 32'd100);
    send_poll(1'b1, 32'd120);
    send_poll(1'b0, 32'd150);
    send_poll(1'b0, 32'd170);
    // Lone click, reported once the timeout has passed.
    send_poll(1'b1, 32'd200);
    send_poll(1'b1, 32'd220);
    send_poll(1'b0, 32'd250);
    send_poll(1'b0, 32'd270);
    send_poll(1'b0, 32'd570);
    // Long press, then its release is swallowed.
    send_poll(1'b1, 32'd600);
    send_poll(1'b1, 32'd620);
    send_poll(1'b1, 32'd1620);
    send_poll(1'b0, 32'd1700);
    send_poll(1'b0, 32'd1720);
    // Debounce across the tick wrap-around.
    send_poll(1'b1, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h0000_0004);
    // A backward step reads as a huge elapsed time.
    send_poll(1'b0, 32'h0000_0010);
    send_poll(1'b0, 32'h0000_0008);
    send_poll(1'b0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Zero thresholds: the level follows at once and a lone release reports at once.
  task automatic test_zero_thresholds();
    set_all(16'd0, 16'hFFFF, 16'd0, 16'd0);
    tick_now = 32'd1000;
    poll_after(1'b1, 0);
    poll_after(1'b0, 1);
    poll_after(1'b1, 1);
    poll_after(1'b0, 0);
    wait_drained();
    set_threshold(bdcc_pkg::REG_LONG, 16'd0);
    poll_after(1'b1, 1);
    poll_after(1'b1, 1);
    poll_after(1'b0, 1);
    wait_drained();
  endtask

  // Largest thresholds.
  task automatic test_max_thresholds();
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    poll_after(1'b1, 5);
    poll_after(1'b1, 32'hFFFE);
    poll_after(1'b1, 1);
    poll_after(1'b1, 32'hFFFF);
    poll_after(1'b0, 3);
    poll_after(1'b0, 32'hFFFF);
    poll_after(1'b1, 1);
    poll_after(1'b1, 32'hFFFF);
    poll_after(1'b0, 1);
    poll_after(1'b0, 32'hFFFF);
    poll_after(1'b0, 32'hFFFF);
    wait_drained();
  endtask

  // Random gestures under fresh small thresholds.
  task automatic test_random_gestures(input int unsigned n_polls);
    int unsigned stop_at;
    int unsigned span;
    int unsigned r;
    set_all(thr_t'($urandom_range(0, 6)), thr_t'($urandom_range(8, 60)),
            thr_t'($urandom_range(4, 40)), thr_t'($urandom_range(4, 40)));
    step_max = $urandom_range(1, 8);
    tick_now = $urandom();
    stop_at = polls_sent + n_polls;
    while (polls_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // Noise: any level at any tick count.
        tick_now = $urandom();
        send_poll(1'($urandom_range(1)), tick_now);
      end else begin
        if (r < 75)
          span = $urandom_range(thr_debounce + 1, thr_debounce + thr_long);
        else
          span = thr_debounce + thr_long + $urandom_range(0, 20);
        hold_level(1'b1, span);
        span = $urandom_range(thr_debounce + 1, thr_debounce + thr_double + thr_single + 10);
        hold_level(1'b0, span);
      end
    end
    wait_drained();
  endtask

  // Results held back for a long stretch while polls keep coming.
  task automatic test_result_holdoff();
    stall_hold_req = 150;
    step_max = 3;
    hold_level(1'b1, thr_debounce + 4);
    hold_level(1'b0, thr_debounce + 4);
    repeat (10) poll_after(1'($urandom_range(1)), $urandom_range(0, 3));
    wait_drained();
  endtask

  initial begin : stimulus
    thr_debounce = bdcc_pkg::RST_DEBOUNCE;
    thr_long = bdcc_pkg::RST_LONG;
    thr_double = bdcc_pkg::RST_DOUBLE;
    thr_single = bdcc_pkg::RST_SINGLE;
    st_stable = 1'b0;
    st_last_raw = 1'b0;
    st_raw_change = '0;
    st_press_start = '0;
    st_long_done = 1'b0;
    st_wait_second = 1'b0;
    st_first_release = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_defaults();
    test_zero_thresholds();
    test_max_thresholds();
    test_random_gestures(70);
    idle_on = 1'b0;
    test_random_gestures(70);
    idle_on = 1'b1;
    test_result_holdoff();
    test_random_gestures(70);
    test_random_gestures(70);
    test_random_gestures(70);

    repeat (10) @(posedge clk);
    $display("Sent %0d polls over default, zero, largest and random thresholds.",
             polls_sent);
    $display("Checked %0d codes: %0d single, %0d double, %0d long, %0d leftover.",
             codes_checked, code_hits[bdcc_pkg::CODE_SINGLE],
             code_hits[bdcc_pkg::CODE_DOUBLE], code_hits[bdcc_pkg::CODE_LONG],
             click_expect_q.size());
    if (error_count == 0 && click_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
